@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

@@ hw/rtl/bstat_pkg.sv @@
// ----------------------------------------------------------------------------
// bstat_pkg
// Types and fixed constants of the block statistics engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bstat_pkg;

  localparam int unsigned CFG_W       = 13;   // block length register
  localparam int unsigned KEY_W       = 16;
  localparam int unsigned IN_VAL_W    = 24;   // sample_value field
  localparam int unsigned OUT_VAL_W   = 24;   // mean/min/max/spread fields
  localparam int unsigned VAR_OUT_W   = 46;   // variance field, unsigned Q46.0
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_FIELDS_W = KEY_W + 4 * OUT_VAL_W + VAR_OUT_W;
  localparam int unsigned OUT_TDATA_W = 160;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [CFG_W-1:0] BLK_LEN_RST = CFG_W'(64);
  localparam logic [63:0]      VAR_SAT     = (64'd1 << VAR_OUT_W) - 64'd1;

  typedef enum logic [3:0] {
    ST_IDLE,      // ready for a sample
    ST_SQUARE,    // multiplier squares the sample magnitude
    ST_ACCUM,     // update count, sums, min and max
    ST_SUM_GO,    // launch divide of |sum|
    ST_SUM_WAIT,
    ST_SQ_GO,     // launch divide of sum of squares
    ST_SQ_WAIT,
    ST_MEAN_SQ,   // multiplier squares the mean magnitude
    ST_FINISH     // build result, wait for free output register
  } bstat_state_e;

endpackage

`default_nettype wire

@@ hw/rtl/bstat_div.sv @@
// ----------------------------------------------------------------------------
// bstat_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bstat_div #(
  parameter int unsigned DIVIDEND_W = 59,
  parameter int unsigned DIVISOR_W  = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,   // must be nonzero
  output logic                  busy_o,
  output logic                  done_o,      // one-cycle pulse, quotient valid
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, done_q;
  logic [STEP_W-1:0]     step_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, dvs_q;

  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W+1:0]  diff;
  logic                  q_bit;
  logic [DIVISOR_W-1:0]  rem_d;

  always_comb begin
    rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, dvs_q};
    q_bit     = ~diff[DIVISOR_W+1];
    rem_d     = q_bit ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(DIVIDEND_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], q_bit};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/block_statistics.sv @@
// ----------------------------------------------------------------------------
// block_statistics
// Mean, min, max, range and population variance over blocks of samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Samples enter on the s_axis stream, one transfer per sample. The block
//    accumulates count, sum, sum of squares, min and max.
//  - The sample that fills a block of the configured length (cfg channel,
//    reset value 64; zero acts as 1, values above MAX_BLOCK act as MAX_BLOCK)
//    produces one result transfer on m_axis and clears the block state.
//  - Each sample is accepted, squared and added before the next is taken;
//    one shared 24x24 multiplier squares samples and the final mean.
//  - A block-closing sample adds two passes of the shared bit-serial divider
//    (mean, then mean of squares), the squaring of the mean and the load of
//    the output register, which raises m_axis_tvalid.
//  - The result sits in an output register: once loaded the block takes new
//    samples at once. If the receiver still holds the previous result when
//    the next block closes, the block waits in its final state and accepts
//    nothing until m_axis_tready frees the register.
//  - Reset clears the block state, drops m_axis_tvalid and loads the block
//    length with 64. Write the block length only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module block_statistics
  import bstat_pkg::*;
#(
  parameter int unsigned MAX_BLOCK   = 4096,
  parameter int unsigned VALUE_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample_key[15:0], sample_value[39:16]
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // block_key[15:0], mean_value[39:16],
                                                // min_value[63:40], max_value[87:64],
                                                // spread[111:88],
                                                // variance_value[157:112], zero[159:158]
  // block length register write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned VW     = VALUE_WIDTH;
  localparam int unsigned LOG_MB = $clog2(MAX_BLOCK);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W  = VW + LOG_MB;          // signed running sum
  localparam int unsigned SQ_W   = 2 * VW - 1 + LOG_MB;  // running sum of squares
  localparam int unsigned PROD_W = 2 * VW;
  localparam int unsigned MSQ_W  = 2 * VW - 1;           // mean of squares

  bstat_state_e state_q, state_d;

  // control outputs of the sequencer
  logic sel_mean_sq;   // multiplier takes the mean magnitude
  logic div_start;
  logic out_load;

  // configuration
  logic [CFG_W-1:0] cfg_q;
  logic [CNT_W-1:0] eff_size;

  // sample capture
  logic [KEY_W-1:0]     key_q;
  logic signed [VW-1:0] sample_q;
  logic [VW-1:0]        sample_mag;

  // accumulators
  logic [CNT_W-1:0]        count_q, count_inc;
  logic [KEY_W-1:0]        first_key_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sqsum_q;
  logic signed [VW-1:0]    min_q, max_q;
  logic                    block_full;

  // shared multiplier
  logic [VW-1:0]     mul_op;
  logic [PROD_W-1:0] prod_q;

  // shared divider
  logic [SUM_W-1:0] sum_mag;
  logic [SQ_W-1:0]  div_dividend;
  logic [SQ_W-1:0]  div_quo;
  logic             div_busy, div_done;

  // finishing
  logic [VW-1:0]    mean_mag_q;
  logic [MSQ_W-1:0] mean_sq_q;
  logic [VW-1:0]    mean_s;
  logic [MSQ_W-1:0] sq_of_mean, var_raw;
  logic [63:0]      var_ext;
  logic [VAR_OUT_W-1:0] var_out;
  logic signed [VW:0]   spread_w;

  // output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= BLK_LEN_RST;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      eff_size = CNT_W'(1);
    end else if (cfg_q > CFG_W'(MAX_BLOCK)) begin
      eff_size = CNT_W'(MAX_BLOCK);
    end else begin
      eff_size = CNT_W'(cfg_q);
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign count_inc  = count_q + CNT_W'(1);
  assign block_full = (count_inc >= eff_size);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_SQUARE;
      ST_SQUARE:   state_d = ST_ACCUM;
      ST_ACCUM:    state_d = block_full ? ST_SUM_GO : ST_IDLE;
      ST_SUM_GO:   state_d = ST_SUM_WAIT;
      ST_SUM_WAIT: if (div_done) state_d = ST_SQ_GO;
      ST_SQ_GO:    state_d = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (div_done) state_d = ST_MEAN_SQ;
      ST_MEAN_SQ:  state_d = ST_FINISH;
      ST_FINISH:   if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    sel_mean_sq   = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_SUM_GO,
      ST_SQ_GO:   div_start = 1'b1;
      ST_MEAN_SQ: sel_mean_sq = 1'b1;
      ST_FINISH:  out_load = !out_valid_q || m_axis_tready;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // sample capture and shared multiplier
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q    <= s_axis_tdata[KEY_W-1:0];
      sample_q <= $signed(s_axis_tdata[KEY_W +: VW]);
    end
  end

  assign sample_mag = sample_q[VW-1] ? (~$unsigned(sample_q) + VW'(1))
                                     : $unsigned(sample_q);
  assign mul_op     = sel_mean_sq ? mean_mag_q : sample_mag;

  // product held outside the two squaring states
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SQUARE || sel_mean_sq) begin
      prod_q <= PROD_W'(mul_op) * PROD_W'(mul_op);
    end
  end

  // --------------------------------------------------------------------------
  // accumulators
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
    end else if (state_q == ST_ACCUM) begin
      count_q <= count_inc;
      sum_q   <= sum_q + SUM_W'(sample_q);
      sqsum_q <= sqsum_q + SQ_W'(prod_q);
    end else if (out_load) begin
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
    end
  end

  // first sample of a block loads key, min and max
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACCUM) begin
      if (count_q == '0) begin
        first_key_q <= key_q;
        min_q       <= sample_q;
        max_q       <= sample_q;
      end else begin
        if (sample_q < min_q) min_q <= sample_q;
        if (sample_q > max_q) max_q <= sample_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // shared divider: |sum| / count, then sum of squares / count
  // --------------------------------------------------------------------------
  assign sum_mag      = sum_q[SUM_W-1] ? (~$unsigned(sum_q) + SUM_W'(1)) : $unsigned(sum_q);
  assign div_dividend = (state_q == ST_SQ_GO) ? sqsum_q : SQ_W'(sum_mag);

  bstat_div #(
    .DIVIDEND_W (SQ_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_done && state_q == ST_SUM_WAIT) mean_mag_q <= div_quo[VW-1:0];
    if (div_done && state_q == ST_SQ_WAIT)  mean_sq_q  <= div_quo[MSQ_W-1:0];
  end

  // --------------------------------------------------------------------------
  // result assembly; prod_q holds mean^2 in ST_FINISH
  // --------------------------------------------------------------------------
  always_comb begin
    mean_s     = sum_q[SUM_W-1] ? (~mean_mag_q + VW'(1)) : mean_mag_q;
    sq_of_mean = prod_q[MSQ_W-1:0];
    var_raw    = (mean_sq_q > sq_of_mean) ? (mean_sq_q - sq_of_mean) : '0;
    var_ext    = 64'(var_raw);
    var_out    = (var_ext > VAR_SAT) ? '1 : var_ext[VAR_OUT_W-1:0];
    spread_w   = {max_q[VW-1], max_q} - {min_q[VW-1], min_q};
    out_data_d = {{OUT_PAD_W{1'b0}},
                  var_out,
                  OUT_VAL_W'(spread_w[VW-1:0]),
                  OUT_VAL_W'(max_q),
                  OUT_VAL_W'(min_q),
                  OUT_VAL_W'($signed(mean_s)),
                  first_key_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEVER(a_ready_while_div, clk_i, rst_ni, s_axis_tready && div_busy,
                "sample accepted while divider busy")
  `ASSERT_PROP(a_done_in_wait, clk_i, rst_ni,
               div_done |-> (state_q == ST_SUM_WAIT || state_q == ST_SQ_WAIT),
               "divider done outside a wait state")
  `ASSERT_PROP(a_accept_to_square, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_SQUARE),
               "accepted sample not squared next cycle")
  `ASSERT_PROP(a_clear_after_result, clk_i, rst_ni,
               out_load |=> (count_q == '0 && m_axis_tvalid),
               "block not cleared after result load")

endmodule

`default_nettype wire

@@ bench/block_statistics_test.sv @@
// ----------------------------------------------------------------------------
// block_statistics_test
// Self-checking bench for the block statistics engine. A clocked driver feeds
// samples and block length writes from a plan queue; a monitor predicts every
// block result (key, mean, min, max, range, variance) and checks each result
// transfer in order against it. Both stream sides idle at random, and the
// result side is held off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module block_statistics_test
  import bstat_pkg::*;
();

  localparam int unsigned MAX_BLOCK   = 4096;
  localparam int unsigned VALUE_WIDTH = 24;

  // End-of-block work is two divider passes plus a multiply, on top of the
  // accept, square and update of a sample. SETTLE covers both with room to spare.
  localparam int unsigned SETTLE      = 200;
  localparam int unsigned DRAIN_QUIET = 8;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned LIMIT       = 1000000;
  localparam int unsigned RAND_ITEMS  = 300;
  localparam int unsigned MAX_REPORTS = 40;

  localparam logic signed [IN_VAL_W-1:0] VAL_MIN = 24'sh800000;
  localparam logic signed [IN_VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;

  // What the driver does with one plan entry.
  typedef enum logic [1:0] {
    OP_SAMPLE,  // one sample transfer
    OP_CONFIG,  // block length write, only once the block has gone quiet
    OP_DRAIN,   // pause until every predicted result has arrived
    OP_HOLD     // start the long result-side hold-off
  } plan_op_e;

  typedef struct {
    plan_op_e                    op;
    logic [KEY_W-1:0]            key;
    logic signed [IN_VAL_W-1:0]  value;
    logic [CFG_W-1:0]            size;
  } plan_entry_t;

  // Same layout as m_axis_tdata: key in the low bits, padding on top.
  typedef struct packed {
    logic [OUT_PAD_W-1:0]  pad;
    logic [VAR_OUT_W-1:0]  variance;
    logic [OUT_VAL_W-1:0]  spread;
    logic [OUT_VAL_W-1:0]  max_v;
    logic [OUT_VAL_W-1:0]  min_v;
    logic [OUT_VAL_W-1:0]  mean;
    logic [KEY_W-1:0]      key;
  } block_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; the bench-driven inputs are known from time zero
  // --------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // sample_key[15:0], sample_value[39:16]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // block_key, mean, min, max, spread,
                                                // variance, zero pad (low to high)
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  logic                   hold_req      = 1'b0; // driver -> receiver, one-cycle pulse

  block_statistics #(
    .MAX_BLOCK   (MAX_BLOCK),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  plan_entry_t   plan_q[$];
  block_result_t expected_blocks[$];

  int unsigned err_cnt      = 0;
  int unsigned samples_seen = 0;
  int unsigned blocks_seen  = 0;
  int unsigned size_writes  = 0;
  int unsigned stall_run    = 0;
  int unsigned stall_max    = 0;

  // Shadow of the block: current register and the open block's accumulators.
  logic [CFG_W-1:0]  acc_size  = BLK_LEN_RST;
  longint unsigned   acc_count = 0;
  logic [KEY_W-1:0]  acc_key   = '0;
  longint            acc_sum   = 0;
  longint unsigned   acc_sqsum = 0;
  longint            acc_min   = 0;
  longint            acc_max   = 0;

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic flag_error(input string what);
    if (err_cnt < MAX_REPORTS)
      $display("ERROR t=%0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("block %0d %s: got 0x%0h, expected 0x%0h",
                           blocks_seen, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Prediction: fold one sample into the open block. Returns 1 when the
  // sample closes the block, with the finished statistics in res.
  // --------------------------------------------------------------------------
  function automatic bit fold_sample(input logic [KEY_W-1:0] key,
                                     input logic signed [IN_VAL_W-1:0] value,
                                     output block_result_t res);
    longint          v;
    longint          cnt;
    longint          mean;
    longint          range_v;
    longint unsigned mag;
    longint unsigned mean_sq;
    longint unsigned mean_mag;
    longint unsigned sq_of_mean;
    longint unsigned variance;
    longint unsigned eff_size;
    v = value;
    res = '0;
    // zero acts as one, anything past MAX_BLOCK saturates
    eff_size = (acc_size == 0) ? 1 : ((acc_size > MAX_BLOCK) ? MAX_BLOCK : acc_size);
    if (acc_count == 0) begin
      acc_key = key;
      acc_min = v;
      acc_max = v;
    end else begin
      if (v < acc_min) acc_min = v;
      if (v > acc_max) acc_max = v;
    end
    acc_sum += v;
    mag = (v < 0) ? -v : v;
    acc_sqsum += mag * mag;
    acc_count++;
    // a shrunk size closes the block as soon as the count reaches or passes it
    if (acc_count < eff_size) return 1'b0;

    cnt        = acc_count;
    mean       = acc_sum / cnt;           // truncates toward zero
    mean_sq    = acc_sqsum / acc_count;
    mean_mag   = (mean < 0) ? -mean : mean;
    sq_of_mean = mean_mag * mean_mag;
    variance   = (mean_sq > sq_of_mean) ? mean_sq - sq_of_mean : 0;
    if (variance > VAR_SAT) variance = VAR_SAT;
    range_v    = acc_max - acc_min;

    res.key      = acc_key;
    res.mean     = mean[OUT_VAL_W-1:0];
    res.min_v    = acc_min[OUT_VAL_W-1:0];
    res.max_v    = acc_max[OUT_VAL_W-1:0];
    res.spread   = range_v[OUT_VAL_W-1:0];
    res.variance = variance[VAR_OUT_W-1:0];

    acc_count = 0;
    acc_key   = '0;
    acc_sum   = 0;
    acc_sqsum = 0;
    acc_min   = 0;
    acc_max   = 0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Idle pattern shared by both sides: mostly short gaps, a few long ones,
  // and now and then a burst of transfers with no gap at all.
  // --------------------------------------------------------------------------
  function automatic int unsigned next_gap(inout int unsigned burst);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) burst = $urandom_range(20, 60);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: issues plan entries on the sample and register channels. Next
  // values are worked out first so each output gets a single NBA per edge;
  // a sample with zero gap keeps tvalid high straight through.
  // --------------------------------------------------------------------------
  int unsigned gap_left   = 0;
  int unsigned quiet_cnt  = 0;
  int unsigned send_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic                  nxt_valid;
    logic                  nxt_cfg;
    logic                  nxt_hold;
    logic [IN_TDATA_W-1:0] nxt_data;
    logic [CFG_W-1:0]      nxt_size;
    plan_entry_t           entry;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
      hold_req      <= 1'b0;
      gap_left       = 0;
      quiet_cnt      = 0;
    end else begin
      nxt_valid = s_axis_tvalid && !s_axis_tready;
      nxt_cfg   = cfg_valid_i && !cfg_ready_o;
      nxt_hold  = 1'b0;
      nxt_data  = s_axis_tdata;
      nxt_size  = cfg_data_i;
      // cycles with no sample offered and no predicted result still due
      quiet_cnt = (expected_blocks.size() == 0 && !s_axis_tvalid) ? quiet_cnt + 1 : 0;
      if (!nxt_valid && !nxt_cfg) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (plan_q.size() != 0) begin
          entry = plan_q[0];
          case (entry.op)
            OP_SAMPLE: begin
              nxt_valid = 1'b1;
              nxt_data  = {entry.value, entry.key};
              plan_q.delete(0);
              gap_left  = next_gap(send_burst);
            end
            OP_CONFIG: begin
              // the block may still chew on a non-closing sample: settle first
              if (quiet_cnt >= SETTLE) begin
                nxt_cfg  = 1'b1;
                nxt_size = entry.size;
                plan_q.delete(0);
              end
            end
            OP_DRAIN: begin
              if (quiet_cnt >= DRAIN_QUIET) plan_q.delete(0);
            end
            OP_HOLD: begin
              nxt_hold = 1'b1;
              plan_q.delete(0);
            end
            default: plan_q.delete(0);
          endcase
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
      cfg_valid_i   <= nxt_cfg;
      cfg_data_i    <= nxt_size;
      hold_req      <= nxt_hold;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls on m_axis_tready, plus one long hold-off counted
  // here once the driver asks for it.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned take_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_ready;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left     = 0;
      hold_left      = 0;
    end else begin
      nxt_ready = 1'b1;
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        if (stall_left == 0 &&
            ((m_axis_tvalid && m_axis_tready) || $urandom_range(0, 19) == 0))
          stall_left = next_gap(take_burst);
        if (stall_left != 0) begin
          stall_left--;
          nxt_ready = 1'b0;
        end
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: tracks register writes and samples into the shadow model and
  // checks each result transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    block_result_t res;
    block_result_t got;
    block_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        acc_size = cfg_data_i;
        size_writes++;
      end

      if (s_axis_tvalid && !s_axis_tready) begin
        stall_run++;
        if (stall_run > stall_max) stall_max = stall_run;
      end else begin
        stall_run = 0;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        samples_seen++;
        if (fold_sample(s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: IN_VAL_W], res))
          expected_blocks.push_back(res);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = block_result_t'(m_axis_tdata);
        if (expected_blocks.size() == 0) begin
          flag_error($sformatf("unexpected result transfer, key 0x%0h", got.key));
        end else begin
          want = expected_blocks.pop_front();
          check_field("block_key", got.key,      want.key);
          check_field("mean",      got.mean,     want.mean);
          check_field("min",       got.min_v,    want.min_v);
          check_field("max",       got.max_v,    want.max_v);
          check_field("spread",    got.spread,   want.spread);
          check_field("variance",  got.variance, want.variance);
          check_field("pad",       got.pad,      want.pad);
        end
        blocks_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Plan building
  // --------------------------------------------------------------------------
  task automatic push_op(input plan_op_e op, input logic [KEY_W-1:0] key,
                         input logic signed [IN_VAL_W-1:0] value,
                         input logic [CFG_W-1:0] size);
    plan_entry_t e;
    e.op    = op;
    e.key   = key;
    e.value = value;
    e.size  = size;
    plan_q.push_back(e);
  endtask

  // mix of rail values, values around zero and full-range noise
  function automatic logic signed [IN_VAL_W-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
    if (pick == 1) return IN_VAL_W'(int'($urandom_range(0, 16)) - 8);
    return IN_VAL_W'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results still due", LIMIT,
             expected_blocks.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rand_cnt;
    int unsigned size;
    int unsigned blocks;
    int unsigned n;
    int unsigned pick;
    rand_cnt = 0;

    // Reset value first: one block of 64 with no write at all.
    for (int i = 0; i < BLK_LEN_RST; i++)
      push_op(OP_SAMPLE, KEY_W'($urandom_range(0, 65535)), rand_value(), '0);

    // Size 1: every sample is its own block; field rails.
    push_op(OP_CONFIG, '0, '0, 1);
    push_op(OP_SAMPLE, 16'h0000, VAL_MIN, '0);
    push_op(OP_SAMPLE, 16'hFFFF, VAL_MAX, '0);
    push_op(OP_SAMPLE, 16'h5555, 0, '0);
    push_op(OP_SAMPLE, 16'hAAAA, -1, '0);
    push_op(OP_SAMPLE, 16'h8001, 1, '0);
    // size zero behaves like one
    push_op(OP_CONFIG, '0, '0, 0);
    push_op(OP_SAMPLE, 16'h1234, 24'sh123456, '0);
    push_op(OP_SAMPLE, 16'hFEDC, -24'sh000FFF, '0);
    // pairs: full range, negative mean truncated toward zero, zero spread
    push_op(OP_CONFIG, '0, '0, 2);
    push_op(OP_SAMPLE, 16'h0101, VAL_MIN, '0);
    push_op(OP_SAMPLE, 16'h0202, VAL_MAX, '0);
    push_op(OP_SAMPLE, 16'h0303, -3, '0);
    push_op(OP_SAMPLE, 16'h0404, -4, '0);
    push_op(OP_SAMPLE, 16'h0505, VAL_MAX, '0);
    push_op(OP_SAMPLE, 16'h0606, VAL_MAX, '0);
    // min moves after the first sample, max stays
    push_op(OP_CONFIG, '0, '0, 3);
    push_op(OP_SAMPLE, 16'h0707, 5, '0);
    push_op(OP_SAMPLE, 16'h0808, -7, '0);
    push_op(OP_SAMPLE, 16'h0909, 3, '0);
    // shrink mid-block below the count: closes on the next sample
    push_op(OP_CONFIG, '0, '0, 8);
    for (int i = 0; i < 5; i++)
      push_op(OP_SAMPLE, KEY_W'(16'h1000 + i), rand_value(), '0);
    push_op(OP_CONFIG, '0, '0, 3);
    push_op(OP_SAMPLE, 16'h1005, rand_value(), '0);
    // shrink mid-block from the largest size: closes when the count reaches it
    push_op(OP_CONFIG, '0, '0, CFG_W'(MAX_BLOCK));
    for (int i = 0; i < 3; i++)
      push_op(OP_SAMPLE, KEY_W'(16'h2000 + i), rand_value(), '0);
    push_op(OP_CONFIG, '0, '0, 5);
    for (int i = 0; i < 2; i++)
      push_op(OP_SAMPLE, KEY_W'(16'h2003 + i), rand_value(), '0);

    // Backpressure: result side held off while size-1 samples keep coming,
    // so the output register fills and the input stalls. Then drain.
    push_op(OP_CONFIG, '0, '0, 1);
    push_op(OP_HOLD, '0, '0, '0);
    for (int i = 0; i < 20; i++)
      push_op(OP_SAMPLE, KEY_W'($urandom_range(0, 65535)), rand_value(), '0);
    push_op(OP_DRAIN, '0, '0, '0);

    // Random phases, mostly small blocks; sometimes a partial block is left
    // open so the next size applies to a block already under way.
    while (rand_cnt < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)      size = $urandom_range(1, 8);
      else if (pick < 9) size = $urandom_range(9, 40);
      else               size = $urandom_range(41, 100);
      blocks = $urandom_range(1, (size < 8) ? 8 : ((size < 40) ? 3 : 1));
      n = size * blocks;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(0, size - 1);
      push_op(OP_CONFIG, '0, '0, CFG_W'(size));
      for (int i = 0; i < n; i++)
        push_op(OP_SAMPLE, KEY_W'($urandom_range(0, 65535)), rand_value(), '0);
      rand_cnt += n;
    end

    // Oversized register acts as the largest block: a run at the negative
    // rail stays open, then a shrink closes it on the next sample.
    push_op(OP_CONFIG, '0, '0, {CFG_W{1'b1}});
    for (int i = 0; i < 8; i++)
      push_op(OP_SAMPLE, KEY_W'($urandom_range(0, 65535)), VAL_MIN, '0);
    push_op(OP_CONFIG, '0, '0, 3);
    push_op(OP_SAMPLE, KEY_W'($urandom_range(0, 65535)), VAL_MIN, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (plan_q.size() != 0 || s_axis_tvalid || cfg_valid_i ||
           expected_blocks.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (expected_blocks.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", expected_blocks.size()));

    $display("Covered %0d samples and %0d block results over %0d length writes (0 to %0d).",
             samples_seen, blocks_seen, size_writes, {CFG_W{1'b1}});
    $display("Longest input stall %0d cycles, %0d mismatches.", stall_max, err_cnt);
    if (err_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
